// ----- rtl/etf_pkg.sv -----
package etf_pkg;

  localparam int COORD_FRAC_BITS = 28;
  localparam int ITER_BITS       = 16;
  localparam int MAX_POWER       = 8;
  localparam int COORD_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR     = 3'd5;

  localparam int CF_SHOW   = 0;
  localparam int CF_GREY   = 1;
  localparam int CF_RED    = 2;
  localparam int CF_GREEN  = 3;
  localparam int CF_BLUE   = 4;
  localparam int CF_INVERT = 5;

  // Product operand select for the shared multiplier.
  typedef enum logic [2:0] {
    MS_RR, MS_II, MS_RI, MS_IR, MS_ZRR, MS_ZII
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // take the point, start z at c
    logic     mul_go;    // issue one product
    mul_sel_t mul_sel;
    logic     esc_eval;  // compare |z|^2 with 4
    logic     cm_re;     // form real part of t*z
    logic     cm_im;     // form imaginary part, update t
    logic     add_c;     // z = t + a
    logic     col_go;    // start colour division
  } etf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic escaped;
    logic col_done;
  } etf_sts_t;

endpackage

// ----- rtl/etf_if.sv -----
interface etf_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [etf_pkg::COORD_W-1:0] c_re;
  logic signed [etf_pkg::COORD_W-1:0] c_im;
  modport source (output valid, c_re, c_im, input ready);
  modport sink   (input valid, c_re, c_im, output ready);
endinterface

interface etf_out_if #(parameter int ITER_BITS = etf_pkg::ITER_BITS);
  logic                 valid;
  logic                 ready;
  logic                 in_set;
  logic [ITER_BITS-1:0] iter_count;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  modport source (output valid, in_set, iter_count, red, green, blue, input ready);
  modport sink   (input valid, in_set, iter_count, red, green, blue, output ready);
endinterface

// ----- rtl/etf_mul.sv -----
// Truncating saturating Q11.F multiplier, magnitude built from four partial
// products, one after another.
module etf_mul #(
  parameter int FRAC = etf_pkg::COORD_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic signed [FRAC+10:0] a,
  input  logic signed [FRAC+10:0] b,
  output logic                done,
  output logic signed [FRAC+10:0] p
);
  import etf_pkg::*;
  localparam int ZW = FRAC + 11;
  localparam int MW = FRAC + 10;          // magnitude bits
  localparam int HW = 11;                 // integer part width of magnitude
  localparam int AW = 2 * ZW + 2;
  localparam logic [AW-1:0] ZMAX = AW'((64'(1) << (FRAC + 10)) - 1);

  logic [MW:0]   ua_r, ub_r;
  logic          neg_r;
  logic [AW-1:0] acc_r;
  logic [2:0]    step_r;
  logic          busy_r;

  logic [HW-1:0]   ah, bh;
  logic [FRAC-1:0] al, bl;
  logic [AW-1:0]   part;
  logic [MW:0]     ma, mb;

  assign ma = a[ZW-1] ? (MW+1)'(-a) : (MW+1)'(a);
  assign mb = b[ZW-1] ? (MW+1)'(-b) : (MW+1)'(b);
  assign ah = HW'(ua_r >> FRAC);
  assign bh = HW'(ub_r >> FRAC);
  assign al = ua_r[FRAC-1:0];
  assign bl = ub_r[FRAC-1:0];

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    part = AW'(AW'(al) * AW'(bl)) >> FRAC;
      2'd1:    part = AW'(AW'(ah) * AW'(bl));
      2'd2:    part = AW'(AW'(al) * AW'(bh));
      default: part = AW'(AW'(ah) * AW'(bh)) << FRAC;
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (go) begin
      ua_r   <= ma;
      ub_r   <= mb;
      neg_r  <= a[ZW-1] ^ b[ZW-1];
      acc_r  <= '0;
      step_r <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      acc_r  <= acc_r + part;
      step_r <= step_r + 3'd1;
      if (step_r == 3'd3) begin
        busy_r <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      p = (acc_r > ZMAX + AW'(1)) ? ZW'(-(ZMAX + AW'(1))) : ZW'(-acc_r);
    end else begin
      p = (acc_r > ZMAX) ? ZW'(ZMAX) : ZW'(acc_r);
    end
  end
endmodule

// ----- rtl/etf_datapath.sv -----
module etf_datapath #(
  parameter int COORD_FRAC_BITS = etf_pkg::COORD_FRAC_BITS,
  parameter int ITER_BITS       = etf_pkg::ITER_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  etf_pkg::etf_cmd_t                cmd,
  output etf_pkg::etf_sts_t                sts,
  input  logic signed [etf_pkg::COORD_W-1:0] c_re,
  input  logic signed [etf_pkg::COORD_W-1:0] c_im,
  input  logic                             julia,
  input  logic signed [etf_pkg::COORD_W-1:0] j_re,
  input  logic signed [etf_pkg::COORD_W-1:0] j_im,
  input  logic [ITER_BITS-1:0]             count,
  input  logic [ITER_BITS-1:0]             budget,
  output logic [7:0]                       quot,
  output logic                             rem_nz
);
  import etf_pkg::*;
  localparam int ZW = COORD_FRAC_BITS + 11;
  localparam logic signed [ZW:0] ZMAX = (ZW+1)'((64'(1) << (COORD_FRAC_BITS + 10)) - 1);
  localparam logic signed [ZW:0] ZMIN = -ZMAX - (ZW+1)'(1);
  localparam logic signed [ZW:0] FOUR = (ZW+1)'(64'(4) << COORD_FRAC_BITS);
  localparam int PW = ITER_BITS + 8;

  logic signed [ZW-1:0] zr_r, zi_r, tr_r, ti_r, ar_r, ai_r, p0_r;
  logic signed [ZW-1:0] ma, mb, mp;
  logic                 mdone;
  logic signed [ZW:0]   sum;

  function automatic logic signed [ZW-1:0] sat(input logic signed [ZW:0] v);
    if (v > ZMAX) return ZMAX[ZW-1:0];
    if (v < ZMIN) return ZMIN[ZW-1:0];
    return v[ZW-1:0];
  endfunction

  always_comb begin
    unique case (cmd.mul_sel)
      MS_RR:   begin ma = tr_r; mb = zr_r; end
      MS_II:   begin ma = ti_r; mb = zi_r; end
      MS_RI:   begin ma = tr_r; mb = zi_r; end
      MS_IR:   begin ma = ti_r; mb = zr_r; end
      MS_ZRR:  begin ma = zr_r; mb = zr_r; end
      default: begin ma = zi_r; mb = zi_r; end
    endcase
  end

  etf_mul #(.FRAC(COORD_FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .go(cmd.mul_go), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  // The products arrive in pairs; the first is held while the second forms,
  // and the second stays on the multiplier output until the next issue.
  always_ff @(posedge clk) begin
    if (mdone && !cmd.cm_re && !cmd.cm_im && cmd.mul_sel != MS_ZII) p0_r <= mp;
  end

  always_comb begin
    if (cmd.cm_re) sum = (ZW+1)'(p0_r) - (ZW+1)'(mp);
    else           sum = (ZW+1)'(p0_r) + (ZW+1)'(mp);
  end

  logic signed [ZW-1:0] tre_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r <= ZW'(c_re);
      zi_r <= ZW'(c_im);
      tr_r <= ZW'(c_re);
      ti_r <= ZW'(c_im);
      ar_r <= julia ? ZW'(j_re) : ZW'(c_re);
      ai_r <= julia ? ZW'(j_im) : ZW'(c_im);
    end else begin
      if (cmd.cm_re) tre_r <= sat(sum);
      if (cmd.cm_im) begin
        tr_r <= tre_r;
        ti_r <= sat(sum);
      end
      if (cmd.add_c) begin
        zr_r <= sat((ZW+1)'(tr_r) + (ZW+1)'(ar_r));
        zi_r <= sat((ZW+1)'(ti_r) + (ZW+1)'(ai_r));
        tr_r <= sat((ZW+1)'(tr_r) + (ZW+1)'(ar_r));
        ti_r <= sat((ZW+1)'(ti_r) + (ZW+1)'(ai_r));
      end
    end
  end

  // Unsaturated sum of the two truncated squares.
  assign sts.escaped  = ((ZW+1)'(p0_r) + (ZW+1)'(mp)) > FOUR;
  assign sts.mul_done = mdone;

  // Restoring division of 255*count by budget, one quotient bit a cycle.
  logic [PW-1:0] rem_r, num_r;
  logic [7:0]    q_r;
  logic [4:0]    dcnt_r;
  logic          dbusy_r, ddone_r;
  logic [PW:0]   trial;

  assign trial = {rem_r, num_r[PW-1]} - (PW+1)'(budget);

  always_ff @(posedge clk) begin
    ddone_r <= 1'b0;
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.col_go) begin
      num_r   <= PW'(count) * PW'(255);
      rem_r   <= '0;
      q_r     <= '0;
      dcnt_r  <= 5'(PW);
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      num_r <= num_r << 1;
      if (!trial[PW]) begin
        rem_r <= trial[PW-1:0];
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        rem_r <= {rem_r[PW-2:0], num_r[PW-1]};
        q_r   <= {q_r[6:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 5'd1;
      if (dcnt_r == 5'd1) begin
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end
    end
  end

  assign sts.col_done = ddone_r;
  assign quot   = q_r;
  assign rem_nz = rem_r != '0;
endmodule

// ----- rtl/etf_ctrl.sv -----
module etf_ctrl #(
  parameter int ITER_BITS = etf_pkg::ITER_BITS,
  parameter int MAX_POWER = etf_pkg::MAX_POWER
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_fire,
  input  logic [15:0]          max_iter,
  input  logic [3:0]           power,
  input  logic                 julia,
  input  logic [5:0]           flags,
  input  etf_pkg::etf_sts_t    sts,
  input  logic [7:0]           quot,
  input  logic                 rem_nz,
  output etf_pkg::etf_cmd_t    cmd,
  output logic                 busy,
  output logic [ITER_BITS-1:0] budget,
  output logic [ITER_BITS-1:0] count,
  output logic                 out_valid,
  output logic                 out_in_set,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue
);
  import etf_pkg::*;
  localparam int PWB = $clog2(MAX_POWER + 1);
  localparam logic [ITER_BITS-1:0] ITER_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ0, S_SQ1, S_TEST, S_M0, S_M1, S_M2, S_M3, S_ADD, S_COL, S_FIN, S_OUT
  } state_t;

  state_t               state_r;
  logic [ITER_BITS-1:0] budget_r, count_r;
  logic [PWB-1:0]       pw_r, k_r;
  logic                 inset_r, waited_r;
  logic [7:0]           r_r, g_r, b_r;
  logic                 valid_r;

  logic [PWB-1:0] pw_sel;
  always_comb begin
    if (julia || power < 4'd2)              pw_sel = PWB'(2);
    else if (32'(power) > MAX_POWER)       pw_sel = PWB'(MAX_POWER);
    else                                    pw_sel = PWB'(power);
  end

  logic [7:0] chan, grey, fin_r, fin_g, fin_b;
  always_comb begin
    grey = 8'd255 - quot - {7'd0, rem_nz};
    fin_r = 8'd0; fin_g = 8'd0; fin_b = 8'd0;
    if (!inset_r) begin
      if (!flags[CF_SHOW]) begin
        fin_r = 8'd255; fin_g = 8'd255; fin_b = 8'd255;
      end else if (flags[CF_GREY]) begin
        fin_r = grey; fin_g = grey; fin_b = grey;
      end else begin
        fin_r = flags[CF_RED]   ? quot : 8'd0;
        fin_g = flags[CF_GREEN] ? quot : 8'd0;
        fin_b = flags[CF_BLUE]  ? quot : 8'd0;
      end
    end
    if (flags[CF_INVERT]) begin
      fin_r = ~fin_r; fin_g = ~fin_g; fin_b = ~fin_b;
    end
    chan = fin_r;
  end

  always_comb begin
    cmd = '0;
    cmd.load     = in_fire;
    unique case (state_r)
      S_SQ0: begin cmd.mul_sel = MS_ZRR; cmd.mul_go = !waited_r; end
      S_SQ1: begin cmd.mul_sel = MS_ZII; cmd.mul_go = !waited_r; end
      S_TEST: cmd.esc_eval = 1'b1;
      S_M0: begin cmd.mul_sel = MS_RR; cmd.mul_go = !waited_r; end
      S_M1: begin cmd.mul_sel = MS_II; cmd.mul_go = !waited_r; cmd.cm_re = sts.mul_done; end
      S_M2: begin cmd.mul_sel = MS_RI; cmd.mul_go = !waited_r; end
      S_M3: begin cmd.mul_sel = MS_IR; cmd.mul_go = !waited_r; cmd.cm_im = sts.mul_done; end
      S_ADD: cmd.add_c = 1'b1;
      default: ;
    endcase
    cmd.col_go = (state_r == S_TEST && waited_r && count_r != budget_r &&
                  sts.escaped && flags[CF_SHOW]);
  end

  // Each multiply state first issues, then waits for the product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= 1'b0;
      waited_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          budget_r <= (32'(max_iter) > 32'(ITER_MAX)) ? ITER_MAX : ITER_BITS'(max_iter);
          pw_r     <= pw_sel;
          count_r  <= '0;
          inset_r  <= 1'b1;
          waited_r <= 1'b0;
          state_r  <= S_TEST;
        end
        S_TEST: begin
          if (count_r == budget_r) begin
            state_r <= S_FIN;
          end else if (!waited_r) begin
            waited_r <= 1'b0;
            state_r  <= S_SQ0;
          end else if (sts.escaped) begin
            inset_r  <= 1'b0;
            waited_r <= 1'b0;
            state_r  <= flags[CF_SHOW] ? S_COL : S_FIN;
          end else begin
            k_r      <= PWB'(1);
            waited_r <= 1'b0;
            state_r  <= S_M0;
          end
        end
        S_SQ0, S_M0, S_M2: begin
          waited_r <= 1'b1;
          if (sts.mul_done) begin
            waited_r <= 1'b0;
            state_r  <= state_t'(state_r + 4'd1);
          end
        end
        S_SQ1: begin
          waited_r <= 1'b1;
          if (sts.mul_done) state_r <= S_TEST;
        end
        S_M1: begin
          waited_r <= 1'b1;
          if (sts.mul_done) begin
            waited_r <= 1'b0;
            state_r  <= S_M2;
          end
        end
        S_M3: begin
          waited_r <= 1'b1;
          if (sts.mul_done) begin
            waited_r <= 1'b0;
            k_r      <= k_r + PWB'(1);
            state_r  <= (k_r + PWB'(1) == pw_r) ? S_ADD : S_M0;
          end
        end
        S_ADD: begin
          count_r <= count_r + ITER_BITS'(1);
          state_r <= S_TEST;
        end
        S_COL: if (sts.col_done) state_r <= S_FIN;
        S_FIN: begin
          r_r <= chan; g_r <= fin_g; b_r <= fin_b;
          valid_r <= 1'b1;
          state_r <= S_OUT;
        end
        default: if (out_fire) begin
          valid_r <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = state_r != S_IDLE;
  assign budget     = budget_r;
  assign count      = count_r;
  assign out_valid  = valid_r;
  assign out_in_set = inset_r;
  assign out_red    = r_r;
  assign out_green  = g_r;
  assign out_blue   = b_r;
endmodule

// ----- rtl/escape_time_fractal_pixel.sv -----
// Escape-time fractal pixel: takes one point c (signed Q4.28) and iterates
// z = z^power + c, or z^2 + the Julia constant, until |z|^2 exceeds 4 or the
// max_iter budget runs out, then returns the in-set flag, the step count and
// an RGB colour. One point is worked on at a time. A single shared multiplier
// sets the rate: each product goes through issue, four partial products and
// done, and a step that does not escape takes two squares for the test and
// power-1 complex products of four real products each, with power taken as 2
// in Julia mode. An escaping point then ends with the final escape test
// and, with colour on, a pass through the colour divider (one quotient bit a
// cycle). Configuration must be written only while idle; the block itself
// does not enforce this.
module escape_time_fractal_pixel #(
  parameter int COORD_FRAC_BITS = etf_pkg::COORD_FRAC_BITS,
  parameter int ITER_BITS       = etf_pkg::ITER_BITS,
  parameter int MAX_POWER       = etf_pkg::MAX_POWER
) (
  input  logic                              clk,
  input  logic                              rst_n,
  etf_in_if.sink                            in_ch,
  etf_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [etf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etf_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import etf_pkg::*;

  logic [15:0]        max_iter_r;
  logic [3:0]         power_r;
  logic               julia_r;
  logic [COORD_W-1:0] jre_r, jim_r;
  logic [5:0]         flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= 16'd30;
      power_r    <= 4'd2;
      julia_r    <= 1'b0;
      jre_r      <= '0;
      jim_r      <= '0;
      flags_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITER:   max_iter_r <= cfg_data[15:0];
        REG_POWER:      power_r    <= cfg_data[3:0];
        REG_JULIA_MODE: julia_r    <= cfg_data[0];
        REG_JULIA_RE:   jre_r      <= cfg_data;
        REG_JULIA_IM:   jim_r      <= cfg_data;
        REG_COLOUR:     flags_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  etf_cmd_t             cmd;
  etf_sts_t             sts;
  logic                 busy, rem_nz;
  logic [7:0]           quot;
  logic [ITER_BITS-1:0] budget, count;
  logic                 in_fire, out_fire;

  assign in_ch.ready = !busy;
  assign in_fire  = in_ch.valid && !busy;
  assign out_fire = out_ch.valid && out_ch.ready;

  etf_ctrl #(.ITER_BITS(ITER_BITS), .MAX_POWER(MAX_POWER)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .max_iter(max_iter_r), .power(power_r), .julia(julia_r), .flags(flags_r),
    .sts(sts), .quot(quot), .rem_nz(rem_nz), .cmd(cmd), .busy(busy),
    .budget(budget), .count(count), .out_valid(out_ch.valid),
    .out_in_set(out_ch.in_set), .out_red(out_ch.red), .out_green(out_ch.green),
    .out_blue(out_ch.blue)
  );

  etf_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .ITER_BITS(ITER_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .c_re(in_ch.c_re), .c_im(in_ch.c_im), .julia(julia_r),
    .j_re(jre_r), .j_im(jim_r), .count(count), .budget(budget),
    .quot(quot), .rem_nz(rem_nz)
  );

  assign out_ch.iter_count = count;
endmodule

// ----- rtl/etf_checker.sv -----
module etf_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_in_set,
  input logic [15:0] out_iter_count
);
  // A finished item holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iter_count))
    else $error("result dropped while stalled");

  // The set flag of a waiting item does not change either.
  a_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_in_set))
    else $error("in_set changed while stalled");

  // No new point is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("point accepted while result pending");

  // An accepted point cannot produce a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind escape_time_fractal_pixel etf_sva u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_in_set(out_ch.in_set), .out_iter_count(out_ch.iter_count[15:0])
);

// ----- bench/etf_checker.sv -----
module etf_checker (
  input  logic      clk,
  input  logic      rst_n,
  etf_in_if         in_ch,
  etf_out_if        out_ch,
  input  logic                          cfg_we,
  input  logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [etf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import etf_pkg::*;

  localparam int FRAC = COORD_FRAC_BITS;
  localparam longint ZMAX = (64'sd1 <<< (FRAC + 10)) - 1;
  localparam longint ZMIN = -(64'sd1 <<< (FRAC + 10));
  localparam bit [63:0] FMASK = (64'd1 << FRAC) - 1;

  typedef struct {
    bit                 in_set;
    bit [ITER_BITS-1:0] iter_count;
    bit [7:0]           red;
    bit [7:0]           green;
    bit [7:0]           blue;
  } pixel_t;

  bit [15:0]        max_iter;
  bit [3:0]         power;
  bit               julia_mode;
  bit signed [31:0] julia_re;
  bit signed [31:0] julia_im;
  bit [5:0]         colour_flags;

  pixel_t pixels_due[$];

  assign pending = pixels_due.size();

  function automatic longint clamp_z(longint v);
    if (v > ZMAX) return ZMAX;
    if (v < ZMIN) return ZMIN;
    return v;
  endfunction

  // Magnitudes are split into integer and fraction parts so that the
  // product is truncated towards zero before the sign is applied.
  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    bit [63:0] ua, ub, ah, al, bh, bl, m;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    ah = ua >> FRAC;
    al = ua & FMASK;
    bh = ub >> FRAC;
    bl = ub & FMASK;
    m = ((ah * bh) << FRAC) + ah * bl + al * bh + ((al * bl) >> FRAC);
    if (neg) begin
      if (m > 64'(ZMAX) + 64'd1) m = 64'(ZMAX) + 64'd1;
      return -longint'(m);
    end
    if (m > 64'(ZMAX)) m = 64'(ZMAX);
    return longint'(m);
  endfunction

  function automatic pixel_t escape_pixel(logic signed [31:0] c_re,
                                          logic signed [31:0] c_im);
    pixel_t p;
    longint ar, ai, zr, zi, tr, ti, nr, ni;
    int unsigned n, budget, pw, prod, q, rem;
    bit esc;
    bit [7:0] r, g, b;
    zr = longint'(c_re);
    zi = longint'(c_im);
    ar = zr;
    ai = zi;
    budget = max_iter;
    pw = (power < 2) ? 2 : (power > MAX_POWER) ? MAX_POWER : power;
    if (julia_mode) begin
      pw = 2;
      ar = longint'(julia_re);
      ai = longint'(julia_im);
    end
    n = 0;
    esc = 0;
    while (n < budget && !esc) begin
      if (fx_mul(zr, zr) + fx_mul(zi, zi) > (64'sd4 <<< FRAC)) begin
        esc = 1;
      end else begin
        tr = zr;
        ti = zi;
        for (int k = 1; k < pw; k++) begin
          nr = clamp_z(fx_mul(tr, zr) - fx_mul(ti, zi));
          ni = clamp_z(fx_mul(tr, zi) + fx_mul(ti, zr));
          tr = nr;
          ti = ni;
        end
        zr = clamp_z(tr + ar);
        zi = clamp_z(ti + ai);
        n++;
      end
    end
    r = 0;
    g = 0;
    b = 0;
    if (esc) begin
      if (colour_flags[CF_SHOW]) begin
        prod = 255 * n;
        q = prod / budget;
        rem = prod % budget;
        if (colour_flags[CF_GREY]) begin
          r = 8'(255 - (q + (rem != 0)));
          g = r;
          b = r;
        end else begin
          if (colour_flags[CF_RED]) r = 8'(q);
          if (colour_flags[CF_GREEN]) g = 8'(q);
          if (colour_flags[CF_BLUE]) b = 8'(q);
        end
      end else begin
        r = 255;
        g = 255;
        b = 255;
      end
    end
    if (colour_flags[CF_INVERT]) begin
      r = 255 - r;
      g = 255 - g;
      b = 255 - b;
    end
    p.in_set = !esc;
    p.iter_count = n[ITER_BITS-1:0];
    p.red = r;
    p.green = g;
    p.blue = b;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      max_iter <= 30;
      power <= 2;
      julia_mode <= 0;
      julia_re <= 0;
      julia_im <= 0;
      colour_flags <= 0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ITER:   max_iter <= cfg_data[15:0];
        REG_POWER:      power <= cfg_data[3:0];
        REG_JULIA_MODE: julia_mode <= cfg_data[0];
        REG_JULIA_RE:   julia_re <= cfg_data;
        REG_JULIA_IM:   julia_im <= cfg_data;
        REG_COLOUR:     colour_flags <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  initial errors = 0;

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pixels_due.push_back(escape_pixel(in_ch.c_re, in_ch.c_im));
      if (out_ch.valid && out_ch.ready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel result with no point waiting");
          errors++;
        end else begin
          want = pixels_due.pop_front();
          if (out_ch.in_set !== want.in_set) begin
            $error("in_set: expected %0d, got %0d", want.in_set, out_ch.in_set);
            errors++;
          end
          if (out_ch.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, got %0d", want.iter_count,
                   out_ch.iter_count);
            errors++;
          end
          if (out_ch.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_ch.red);
            errors++;
          end
          if (out_ch.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_ch.green);
            errors++;
          end
          if (out_ch.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_ch.blue);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import etf_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int POINT_TARGET = 1550;
  localparam logic signed [31:0] ONE = 32'sh1000_0000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  etf_in_if  in_ch ();
  etf_out_if out_ch ();

  int errors, pending, points_sent, phases;
  longint cycles;
  bit gaps_on, stalls_on, took;
  int stall_left;

  escape_time_fractal_pixel dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  etf_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: a random stall before each item, or none in quiet phases.
  always @(posedge clk) took <= out_ch.valid && out_ch.ready;

  always @(negedge clk) begin
    if (took) stall_left = stalls_on ? $urandom_range(0, 9) : 0;
    if (stall_left > 0) begin
      out_ch.ready <= 0;
      stall_left--;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_mode(int unsigned iters, int unsigned pw, bit julia,
                          logic [31:0] jre, logic [31:0] jim, logic [5:0] flags);
    write_reg(REG_MAX_ITER, iters);
    write_reg(REG_POWER, pw);
    write_reg(REG_JULIA_MODE, 32'(julia));
    write_reg(REG_JULIA_RE, jre);
    write_reg(REG_JULIA_IM, jim);
    write_reg(REG_COLOUR, 32'(flags));
    cfg_we <= 0;
    @(negedge clk);
    phases++;
  endtask

  task automatic send_point(logic signed [31:0] re, logic signed [31:0] im);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.c_re <= re;
    in_ch.c_im <= im;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    points_sent++;
  endtask

  // Every configuration change waits for the block to drain.
  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  function automatic logic [31:0] near_coord();
    return $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 32'h4000_0000))
           - 32'sh2000_0000);
  endfunction

  initial begin
    int unsigned iters, pw, n;
    logic [31:0] jre, jim;
    in_ch.valid = 0;
    in_ch.c_re = 0;
    in_ch.c_im = 0;
    out_ch.ready = 0;
    gaps_on = 1;
    stalls_on = 1;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Reset configuration: origin stays in the set, corners escape at once.
    send_point(0, 0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(-2 * ONE, 0);
    send_point(ONE / 4, 0);
    send_point(0, ONE);
    drain();

    // Zero budget gives black, shown white under invert.
    set_mode(0, 2, 0, 0, 0, 6'h20);
    send_point(ONE, ONE);
    send_point(32'sh8000_0000, 0);
    drain();

    // Largest budget with the exponent clamped down; only escaping points.
    set_mode(65535, 15, 0, 0, 0, 6'h1D);
    send_point(ONE, 0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_point(0, 3 * ONE / 2);
    drain();
    set_mode(65535, 8, 0, 0, 0, 6'h03);
    send_point(ONE, ONE / 2);
    send_point(-3 * ONE, 0);
    drain();

    // Julia rule with extreme constants, saturating arithmetic, one step.
    set_mode(1, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 6'h3F);
    send_point(0, 0);
    send_point(ONE / 2, -ONE / 2);
    send_point(32'sh7FFF_FFFF, 0);
    drain();

    // A write to an unused index must leave the registers alone.
    write_reg(3'd7, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h0000_0000);
    cfg_we <= 0;
    @(negedge clk);
    set_mode(40, 3, 1, 32'hF400_0000, 32'h02C0_0000, 6'h15);
    send_point(0, 0);
    send_point(ONE / 3, ONE / 5);
    send_point(-ONE, ONE / 8);
    drain();

    while (points_sent < POINT_TARGET) begin
      pw = $urandom_range(0, 15);
      iters = (pw > 4) ? $urandom_range(1, 16) : $urandom_range(1, 32);
      if ($urandom_range(0, 15) == 0) iters = $urandom_range(0, 1);
      jre = near_coord();
      jim = near_coord();
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      set_mode(iters, pw, $urandom_range(0, 3) == 0, jre, jim, 6'($urandom_range(0, 63)));
      n = $urandom_range(20, 60);
      repeat (n) send_point(near_coord(), near_coord());
      drain();
    end

    repeat (50) @(negedge clk);
    $display("Escape-time run: %0d points over %0d register settings, Mandelbrot",
             points_sent, phases);
    $display("and Julia rules, exponents 0 to 15, budgets 0 to 65535, all colour modes.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/etf_pkg.sv
rtl/etf_if.sv
rtl/etf_mul.sv
rtl/etf_datapath.sv
rtl/etf_ctrl.sv
rtl/escape_time_fractal_pixel.sv
rtl/etf_checker.sv
bench/etf_checker.sv
bench/testbench.sv
